// ----- rtl/csem_pkg.sv -----
// ----------------------------------------------------------------------------
// csem_pkg
// shared codes, field widths and types for the counting semaphore table
// ----------------------------------------------------------------------------
package csem_pkg;

    // request field widths
    localparam int FUNC_W   = 2;
    localparam int SEM_ID_W = 4;
    localparam int INIT_W   = 16;
    localparam int PID_IN_W = 8;

    // result field widths
    localparam int STATUS_W   = 3;
    localparam int NEW_ID_W   = 4;
    localparam int COUNT_O_W  = 16;
    localparam int PID_OUT_W  = 8;

    // packed beat widths, rounded up to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WAIT    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_POST    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADID    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LOCKED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_QFULL    = 3'd5;

    // free list command for one commit
    typedef struct packed {
        logic pop;
        logic push;
    } free_req_t;

endpackage

// ----- rtl/counting_semaphore_table.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_table
// table of counting semaphores with per-semaphore fifo wait queues and a
// fifo free list of semaphore ids
// ----------------------------------------------------------------------------
// throughput: one request beat per cycle while m_ does not stall;
//   the input register, count and pointer rams are read at accept
//   and written back at the commit edge
// reset: synchronous on aresetn low; all semaphores free, ids 0 upwards,
//   no clearing pass, the rams hold no state that matters until written
module counting_semaphore_table #(
    parameter int NUM_SEMS   = 16,
    parameter int WAIT_DEPTH = 16,
    parameter int PID_BITS   = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request beat
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sem_id[3:0], init_value[19:4], caller_pid[27:20]
    input  logic [csem_pkg::S_TDATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [csem_pkg::FUNC_W-1:0]     s_tuser,
    // result beat
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[2:0], new_id[6:3], count_now[22:7], blocked[23],
    // wake_valid[24], wake_pid[32:25]
    output logic [csem_pkg::M_TDATA_W-1:0]  m_tdata
);
    import csem_pkg::*;

    localparam int SEM_W   = $clog2(NUM_SEMS);
    localparam int WQ_AW   = WAIT_DEPTH > 1 ? $clog2(WAIT_DEPTH) : 1;
    localparam int WQ_FW   = $clog2(WAIT_DEPTH + 1);
    localparam int PTR_W   = WQ_AW + WQ_FW;
    localparam int PID_AW  = SEM_W + WQ_AW;
    localparam int PID_DEP = NUM_SEMS * (1 << WQ_AW);
    localparam int CMP_W   = COUNT_BITS > INIT_W ? COUNT_BITS : INIT_W;

    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
    localparam logic [CMP_W-1:0]      CNT_MAX_X = CMP_W'(CNT_MAX);
    localparam logic [8:0]            NSEM_V    = 9'(NUM_SEMS);
    localparam logic [WQ_FW-1:0]      WQ_FULL   = WQ_FW'(WAIT_DEPTH);
    localparam logic [WQ_AW-1:0]      WQ_LAST   = WQ_AW'(WAIT_DEPTH - 1);
    localparam logic [WQ_AW:0]        WD_V      = (WQ_AW + 1)'(WAIT_DEPTH);

    // handshake
    logic s_fire, advance_b, commit;

    // input register
    logic                a_valid_reg;
    logic [FUNC_W-1:0]   a_func_reg;
    logic [SEM_ID_W-1:0] a_sem_id_reg;
    logic [INIT_W-1:0]   a_init_reg;
    logic [PID_BITS-1:0] a_pid_reg;

    // result register
    logic                 b_valid_reg;
    logic [STATUS_W-1:0]  b_status_reg;
    logic [NEW_ID_W-1:0]  b_new_id_reg;
    logic [COUNT_O_W-1:0] b_count_reg;
    logic                 b_blocked_reg;
    logic                 b_wake_reg;

    // unpacked request
    logic [SEM_ID_W-1:0] s_sem_id;
    logic [SEM_W-1:0]    s_idx;

    // ram ports
    logic                  cnt_we;
    logic [SEM_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic                  ptr_we;
    logic [SEM_W-1:0]      ptr_waddr;
    logic [PTR_W-1:0]      ptr_wdata, ptr_rdata;
    logic                  pid_we, pid_re;
    logic [PID_AW-1:0]     pid_waddr, pid_raddr;
    logic [PID_BITS-1:0]   pid_rdata;

    // write-back bypass captured at accept
    logic                  cnt_hit_reg, ptr_hit_reg;
    logic [COUNT_BITS-1:0] cnt_fwd_reg;
    logic [PTR_W-1:0]      ptr_fwd_reg;

    // free list
    free_req_t        free_req;
    logic             free_empty;
    logic [SEM_W-1:0] free_head_id;

    // allocation flags
    logic [NUM_SEMS-1:0] alloc_reg;
    logic                flag_set, flag_clr;
    logic [SEM_W-1:0]    flag_idx;

    // execute stage values
    logic [SEM_W-1:0]      a_idx;
    logic                  in_range;
    logic [COUNT_BITS-1:0] a_cnt;
    logic [WQ_AW-1:0]      a_head;
    logic [WQ_FW-1:0]      a_fill;
    logic [WQ_AW:0]        tail_sum;
    logic [WQ_AW-1:0]      tail;
    logic [CMP_W-1:0]      init_ext;
    logic [COUNT_BITS-1:0] init_sat;
    logic [STATUS_W-1:0]   status_next;
    logic [NEW_ID_W-1:0]   new_id_next;
    logic [COUNT_BITS-1:0] count_next;
    logic                  blocked_next, wake_next;

    assign s_sem_id  = s_tdata[3:0];
    assign s_idx     = SEM_W'(s_sem_id);

    assign advance_b = !b_valid_reg || m_tready;
    assign commit    = a_valid_reg && advance_b;
    assign s_tready  = !a_valid_reg || advance_b;
    assign s_fire    = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_fire) begin
            a_valid_reg <= 1'b1;
        end else if (commit) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_func_reg   <= s_tuser;
            a_sem_id_reg <= s_sem_id;
            a_init_reg   <= s_tdata[19:4];
            a_pid_reg    <= PID_BITS'(s_tdata[27:20]);
            cnt_fwd_reg  <= cnt_wdata;
            ptr_fwd_reg  <= ptr_wdata;
        end
    end

    // a write-back to the entry read on the same edge is caught here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_hit_reg <= 1'b0;
            ptr_hit_reg <= 1'b0;
        end else if (s_fire) begin
            cnt_hit_reg <= cnt_we && (cnt_waddr == s_idx);
            ptr_hit_reg <= ptr_we && (ptr_waddr == s_idx);
        end
    end

    // operands of the held request
    assign a_idx    = SEM_W'(a_sem_id_reg);
    assign in_range = (9'(a_sem_id_reg) < NSEM_V);
    assign a_cnt    = cnt_hit_reg ? cnt_fwd_reg : cnt_rdata;
    assign {a_head, a_fill} = ptr_hit_reg ? ptr_fwd_reg : ptr_rdata;

    // next free slot of the wait queue
    always_comb begin
        tail_sum = {1'b0, a_head} + (WQ_AW + 1)'(a_fill);
        if (tail_sum >= WD_V) begin
            tail = WQ_AW'(tail_sum - WD_V);
        end else begin
            tail = WQ_AW'(tail_sum);
        end
    end

    // starting count clipped to the count range
    always_comb begin
        init_ext = CMP_W'(a_init_reg);
        init_sat = (init_ext > CNT_MAX_X) ? CNT_MAX : COUNT_BITS'(init_ext);
    end

    // request decode and state update
    always_comb begin
        status_next   = ST_OK;
        new_id_next   = '0;
        count_next    = '0;
        blocked_next  = 1'b0;
        wake_next     = 1'b0;
        cnt_we        = 1'b0;
        cnt_waddr     = a_idx;
        cnt_wdata     = a_cnt;
        ptr_we        = 1'b0;
        ptr_waddr     = a_idx;
        ptr_wdata     = {a_head, a_fill};
        pid_we        = 1'b0;
        pid_re        = 1'b0;
        pid_waddr     = {a_idx, tail};
        pid_raddr     = {a_idx, a_head};
        free_req.pop  = 1'b0;
        free_req.push = 1'b0;
        flag_set      = 1'b0;
        flag_clr      = 1'b0;
        flag_idx      = a_idx;

        if (a_func_reg == FUNC_ALLOC) begin
            if (free_empty) begin
                status_next = ST_NOFREE;
            end else begin
                free_req.pop = commit;
                flag_set     = commit;
                flag_idx     = free_head_id;
                cnt_we       = commit;
                cnt_waddr    = free_head_id;
                cnt_wdata    = init_sat;
                ptr_we       = commit;
                ptr_waddr    = free_head_id;
                ptr_wdata    = '0;
                new_id_next  = NEW_ID_W'(free_head_id);
                count_next   = init_sat;
            end
        end else if (!in_range) begin
            status_next = ST_BADID;
        end else if (!alloc_reg[a_idx]) begin
            status_next = ST_NOTALLOC;
        end else begin
            unique case (a_func_reg)
                FUNC_DESTROY: begin
                    if (a_cnt == '0) begin
                        status_next = ST_LOCKED;
                    end else begin
                        free_req.push = commit;
                        flag_clr      = commit;
                    end
                end
                FUNC_WAIT: begin
                    if (a_cnt == '0) begin
                        if (a_fill == WQ_FULL) begin
                            status_next = ST_QFULL;
                        end else begin
                            pid_we       = commit;
                            ptr_we       = commit;
                            ptr_wdata    = {a_head, a_fill + 1'b1};
                            blocked_next = 1'b1;
                        end
                    end else begin
                        cnt_we     = commit;
                        cnt_wdata  = a_cnt - 1'b1;
                        count_next = a_cnt - 1'b1;
                    end
                end
                FUNC_POST: begin
                    count_next = a_cnt;
                    if (a_fill != '0) begin
                        pid_re    = commit;
                        ptr_we    = commit;
                        ptr_wdata = {(a_head == WQ_LAST) ? WQ_AW'(0) : a_head + 1'b1,
                                     a_fill - 1'b1};
                        wake_next = 1'b1;
                    end else if (a_cnt != CNT_MAX) begin
                        cnt_we     = commit;
                        cnt_wdata  = a_cnt + 1'b1;
                        count_next = a_cnt + 1'b1;
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // allocation flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg <= '0;
        end else if (flag_set) begin
            alloc_reg[flag_idx] <= 1'b1;
        end else if (flag_clr) begin
            alloc_reg[flag_idx] <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            b_status_reg  <= status_next;
            b_new_id_reg  <= new_id_next;
            b_count_reg   <= COUNT_O_W'(count_next);
            b_blocked_reg <= blocked_next;
            b_wake_reg    <= wake_next;
        end
    end

    // semaphore counts
    csem_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_SEMS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (s_fire),
        .raddr (s_idx),
        .rdata (cnt_rdata)
    );

    // wait queue head and fill
    csem_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NUM_SEMS)
    ) u_ptr_ram (
        .aclk  (aclk),
        .we    (ptr_we),
        .waddr (ptr_waddr),
        .wdata (ptr_wdata),
        .re    (s_fire),
        .raddr (s_idx),
        .rdata (ptr_rdata)
    );

    // queued pids, one row per semaphore
    csem_ram #(
        .WIDTH (PID_BITS),
        .DEPTH (PID_DEP)
    ) u_pid_ram (
        .aclk  (aclk),
        .we    (pid_we),
        .waddr (pid_waddr),
        .wdata (a_pid_reg),
        .re    (pid_re),
        .raddr (pid_raddr),
        .rdata (pid_rdata)
    );

    csem_free_list #(
        .NUM_SEMS (NUM_SEMS)
    ) u_free_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .req     (free_req),
        .push_id (a_idx),
        .empty   (free_empty),
        .head_id (free_head_id)
    );

    // result beat
    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {7'd0,
                       b_wake_reg ? PID_OUT_W'(pid_rdata) : PID_OUT_W'(0),
                       b_wake_reg,
                       b_blocked_reg,
                       b_count_reg,
                       b_new_id_reg,
                       b_status_reg};

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_status_reg != ST_OK) |->
            (b_count_reg == '0 && b_new_id_reg == '0 && !b_blocked_reg && !b_wake_reg))
        else $error("error result carries data");

    a_block_wake_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> !(b_blocked_reg && b_wake_reg))
        else $error("result both blocked and woke");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (a_valid_reg && b_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

// ----- rtl/csem_ram.sv -----
// ----------------------------------------------------------------------------
// csem_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/csem_free_list.sv -----
// ----------------------------------------------------------------------------
// csem_free_list
// circular free list of semaphore ids, issuing 0 .. NUM_SEMS-1 after reset
// ----------------------------------------------------------------------------
module csem_free_list #(
    parameter int NUM_SEMS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  csem_pkg::free_req_t           req,
    input  logic [$clog2(NUM_SEMS)-1:0]   push_id,
    output logic                          empty,
    output logic [$clog2(NUM_SEMS)-1:0]   head_id
);
    import csem_pkg::*;

    localparam int SEM_W = $clog2(NUM_SEMS);
    localparam int FF_W  = $clog2(NUM_SEMS + 1);
    localparam logic [SEM_W-1:0] LAST_ID = SEM_W'(NUM_SEMS - 1);
    localparam logic [SEM_W:0]   N_V     = (SEM_W + 1)'(NUM_SEMS);
    localparam logic [FF_W-1:0]  FULL_V  = FF_W'(NUM_SEMS);

    logic [SEM_W-1:0]    head_reg, head_next;
    logic [FF_W-1:0]     fill_reg, fill_next;
    logic [NUM_SEMS-1:0] written_reg;
    logic                fwd_hit_reg;
    logic [SEM_W-1:0]    fwd_id_reg;
    logic [SEM_W:0]      tail_sum;
    logic [SEM_W-1:0]    tail;
    logic                push_ok;
    logic [SEM_W-1:0]    rdata;

    // tail slot, head + fill wrapped once
    always_comb begin
        tail_sum = {1'b0, head_reg} + (SEM_W + 1)'(fill_reg);
        if (tail_sum >= N_V) begin
            tail = SEM_W'(tail_sum - N_V);
        end else begin
            tail = SEM_W'(tail_sum);
        end
    end

    assign push_ok = req.push && (fill_reg != FULL_V);

    // pointer update
    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (req.pop) begin
            head_next = (head_reg == LAST_ID) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end else if (push_ok) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            fill_reg    <= FULL_V;
            written_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            if (push_ok) begin
                written_reg[tail] <= 1'b1;
            end
            // a push into the slot being read this edge bypasses the ram
            if (rd_en) begin
                fwd_hit_reg <= push_ok && (tail == head_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_id_reg <= push_id;
        end
    end

    // id store, read ahead at the next head
    csem_ram #(
        .WIDTH (SEM_W),
        .DEPTH (NUM_SEMS)
    ) u_id_ram (
        .aclk  (aclk),
        .we    (push_ok),
        .waddr (tail),
        .wdata (push_id),
        .re    (rd_en),
        .raddr (head_next),
        .rdata (rdata)
    );

    // slots never pushed still hold their reset id
    assign empty   = (fill_reg == '0);
    assign head_id = written_reg[head_reg] ? (fwd_hit_reg ? fwd_id_reg : rdata) : head_reg;

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        req.pop |-> fill_reg != '0)
        else $error("free list popped while empty");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_V)
        else $error("free list fill beyond id count");

    a_pop_push_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.pop && req.push))
        else $error("free list pop and push in one commit");

endmodule
